// ===== hdl/rar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, types and helpers of the rational add/multiply/reduce unit.
// ----------------------------------------------------------------------------
package rar_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
	localparam int WORK_WIDTH    = PROD_WIDTH + 2;
	localparam int NUM_WIDTH     = 33;
	localparam int DEN_WIDTH     = 32;
	localparam int MUL_CNT_WIDTH = $clog2(OPERAND_WIDTH);
	localparam int DIV_CNT_WIDTH = $clog2(WORK_WIDTH);

	localparam logic [1:0] FUNC_MUL    = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_REDUCE = 2'd2;
	localparam logic [1:0] FUNC_RSVD   = 2'd3;

	typedef logic signed [OPERAND_WIDTH-1:0] opnd_t;
	typedef logic [OPERAND_WIDTH-1:0]        mag_t;
	typedef logic [PROD_WIDTH-1:0]           prod_t;
	typedef logic signed [WORK_WIDTH-1:0]    work_t;
	typedef logic [WORK_WIDTH-1:0]           wmag_t;

	typedef struct packed {
		logic  done;
		prod_t prod;
	} mul_out_t;

	typedef struct packed {
		logic  done;
		wmag_t quo;
		wmag_t rem;
	} div_out_t;

	function automatic mag_t abs_opnd(opnd_t v);
		logic [OPERAND_WIDTH:0] e;
		e = {v[OPERAND_WIDTH-1], v};
		if (v[OPERAND_WIDTH-1]) begin
			e = -e;
		end
		return e[OPERAND_WIDTH-1:0];
	endfunction

	function automatic wmag_t abs_work(work_t v);
		return v[WORK_WIDTH-1] ? wmag_t'(-v) : wmag_t'(v);
	endfunction

	function automatic work_t apply_sign(wmag_t m, logic neg);
		return neg ? -work_t'(m) : work_t'(m);
	endfunction

endpackage

// ===== hdl/rar_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_in_if
// Request channel: operation code and two fractions.
// ----------------------------------------------------------------------------
interface rar_in_if;
	logic          valid;
	logic          ready;
	logic [1:0]    func;
	rar_pkg::opnd_t a_num;
	rar_pkg::opnd_t a_den;
	rar_pkg::opnd_t b_num;
	rar_pkg::opnd_t b_den;

	modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hdl/rar_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_out_if
// Result channel: numerator, denominator and status.
// ----------------------------------------------------------------------------
interface rar_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rar_pkg::NUM_WIDTH-1:0]  res_num;
	logic signed [rar_pkg::DEN_WIDTH-1:0]  res_den;
	logic                                  status;

	modport source (output valid, res_num, res_den, status, input ready);
	modport sink (input valid, res_num, res_den, status, output ready);
endinterface

// ===== hdl/rar_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_mul
// Bit-serial shift-add multiplier of two unsigned operand magnitudes.
// ----------------------------------------------------------------------------
module rar_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rar_pkg::mag_t     op_a,
	input  rar_pkg::mag_t     op_b,
	output rar_pkg::mul_out_t res
);

	logic                              busy_q;
	logic [rar_pkg::MUL_CNT_WIDTH-1:0] cnt_q;
	rar_pkg::prod_t                    mcand_q;
	rar_pkg::mag_t                     mplier_q;
	rar_pkg::prod_t                    acc_q;
	logic                              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rar_pkg::MUL_CNT_WIDTH'(rar_pkg::OPERAND_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= rar_pkg::prod_t'(op_a);
			mplier_q <= op_b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign res.done = done_q;
	assign res.prod = acc_q;

endmodule

// ===== hdl/rar_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_div
// Bit-serial restoring divider: quotient and remainder of two magnitudes.
// ----------------------------------------------------------------------------
module rar_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rar_pkg::wmag_t    dividend,
	input  rar_pkg::wmag_t    divisor,
	output rar_pkg::div_out_t res
);

	logic                              busy_q;
	logic                              done_q;
	logic [rar_pkg::DIV_CNT_WIDTH-1:0] cnt_q;
	rar_pkg::wmag_t                    quo_q;
	logic [rar_pkg::WORK_WIDTH:0]      rem_q;
	rar_pkg::wmag_t                    dvs_q;
	logic [rar_pkg::WORK_WIDTH:0]      shifted;
	logic [rar_pkg::WORK_WIDTH:0]      trial;

	assign shifted = {rem_q[rar_pkg::WORK_WIDTH-1:0], quo_q[rar_pkg::WORK_WIDTH-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rar_pkg::DIV_CNT_WIDTH'(rar_pkg::WORK_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[rar_pkg::WORK_WIDTH]) begin
				rem_q <= trial;
				quo_q <= {quo_q[rar_pkg::WORK_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[rar_pkg::WORK_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q[rar_pkg::WORK_WIDTH-1:0];

endmodule

// ===== hdl/rational_add_mul_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_mul_reduce
// Multiplies, adds and reduces fractions with serial multiply/divide units.
// Throughput: one request at a time; the next is taken once the sequencer is
// idle, while a finished result may still wait in the output register.
// Reset clears the sequencer, both serial units and the output valid flag.
// ----------------------------------------------------------------------------
module rational_add_mul_reduce (
	input  logic       clk,
	input  logic       arst_n,
	rar_in_if.sink     in_ch,
	rar_out_if.source  out_ch
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_MULW  = 4'd2;
	localparam logic [3:0] S_EINIT = 4'd3;
	localparam logic [3:0] S_EUC   = 4'd4;
	localparam logic [3:0] S_EUCW  = 4'd5;
	localparam logic [3:0] S_QN    = 4'd6;
	localparam logic [3:0] S_QNW   = 4'd7;
	localparam logic [3:0] S_QD    = 4'd8;
	localparam logic [3:0] S_QDW   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0]        state_q;
	logic [1:0]        k_q;
	logic              err_q;
	logic [1:0]        func_q;
	rar_pkg::opnd_t    an_q, ad_q, bn_q, bd_q;
	rar_pkg::work_t    num_q, den_q, x_q, y_q;
	logic              out_valid_q;
	logic signed [rar_pkg::NUM_WIDTH-1:0] out_num_q;
	logic signed [rar_pkg::DEN_WIDTH-1:0] out_den_q;
	logic              out_status_q;

	rar_pkg::opnd_t    mop_a, mop_b;
	logic              mul_start;
	rar_pkg::mul_out_t mul_res;
	rar_pkg::work_t    prod_s;
	logic              div_start;
	rar_pkg::wmag_t    dop_n, dop_d;
	rar_pkg::div_out_t div_res;
	logic              in_err;
	logic              out_free;

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_err = (in_ch.func == rar_pkg::FUNC_RSVD) || (in_ch.a_den == '0) ||
		((in_ch.func != rar_pkg::FUNC_REDUCE) && (in_ch.b_den == '0));

	always_comb begin
		unique case (k_q)
			2'd0: begin
				mop_a = ad_q;
				mop_b = bd_q;
			end
			2'd1: begin
				mop_a = an_q;
				mop_b = (func_q == rar_pkg::FUNC_MUL) ? bn_q : bd_q;
			end
			default: begin
				mop_a = bn_q;
				mop_b = ad_q;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_EUC: begin
				dop_n = rar_pkg::abs_work(x_q);
				dop_d = rar_pkg::abs_work(y_q);
			end
			S_QN: begin
				dop_n = rar_pkg::abs_work(num_q);
				dop_d = rar_pkg::abs_work(x_q);
			end
			default: begin
				dop_n = rar_pkg::abs_work(den_q);
				dop_d = rar_pkg::abs_work(x_q);
			end
		endcase
	end

	assign mul_start = (state_q == S_MUL);
	assign div_start = (state_q == S_EUC && y_q != '0) || state_q == S_QN || state_q == S_QD;
	assign prod_s = rar_pkg::apply_sign(rar_pkg::wmag_t'(mul_res.prod),
		mop_a[rar_pkg::OPERAND_WIDTH-1] ^ mop_b[rar_pkg::OPERAND_WIDTH-1]);

	rar_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (rar_pkg::abs_opnd(mop_a)),
		.op_b   (rar_pkg::abs_opnd(mop_b)),
		.res    (mul_res)
	);

	rar_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dop_n),
		.divisor  (dop_d),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_FIN && out_free) || (out_valid_q && !out_ch.ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						err_q <= in_err;
						k_q   <= '0;
						if (in_err) begin
							state_q <= S_FIN;
						end else if (in_ch.func == rar_pkg::FUNC_REDUCE) begin
							state_q <= S_EINIT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: state_q <= S_MULW;
				S_MULW: begin
					if (mul_res.done) begin
						k_q <= k_q + 1'b1;
						if (k_q == 2'd2) begin
							state_q <= S_EINIT;
						end else if (k_q == 2'd1 && func_q == rar_pkg::FUNC_MUL) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_EINIT: state_q <= S_EUC;
				S_EUC: begin
					if (y_q == '0) begin
						if (x_q == '0) begin
							err_q   <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_QN;
						end
					end else begin
						state_q <= S_EUCW;
					end
				end
				S_EUCW: if (div_res.done) state_q <= S_EUC;
				S_QN: state_q <= S_QNW;
				S_QNW: if (div_res.done) state_q <= S_QD;
				S_QD: state_q <= S_QDW;
				S_QDW: if (div_res.done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			func_q <= in_ch.func;
			an_q   <= in_ch.a_num;
			ad_q   <= in_ch.a_den;
			bn_q   <= in_ch.b_num;
			bd_q   <= in_ch.b_den;
			num_q  <= rar_pkg::work_t'(in_ch.a_num);
			den_q  <= rar_pkg::work_t'(in_ch.a_den);
		end
		if (state_q == S_MULW && mul_res.done) begin
			unique case (k_q)
				2'd0:    den_q <= prod_s;
				2'd1:    num_q <= prod_s;
				default: num_q <= num_q + prod_s;
			endcase
		end
		if (state_q == S_EINIT) begin
			x_q <= (num_q > den_q) ? num_q : den_q;
			y_q <= (num_q > den_q) ? den_q : num_q;
		end
		if (state_q == S_EUCW && div_res.done) begin
			x_q <= y_q;
			y_q <= rar_pkg::apply_sign(div_res.rem, x_q[rar_pkg::WORK_WIDTH-1]);
		end
		if (state_q == S_QNW && div_res.done) begin
			num_q <= rar_pkg::apply_sign(div_res.quo,
				num_q[rar_pkg::WORK_WIDTH-1] ^ x_q[rar_pkg::WORK_WIDTH-1]);
		end
		if (state_q == S_QDW && div_res.done) begin
			den_q <= rar_pkg::apply_sign(div_res.quo,
				den_q[rar_pkg::WORK_WIDTH-1] ^ x_q[rar_pkg::WORK_WIDTH-1]);
		end
		if (state_q == S_FIN && out_free) begin
			out_num_q    <= err_q ? '0 : num_q[rar_pkg::NUM_WIDTH-1:0];
			out_den_q    <= err_q ? '0 : den_q[rar_pkg::DEN_WIDTH-1:0];
			out_status_q <= err_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.res_num = out_num_q;
	assign out_ch.res_den = out_den_q;
	assign out_ch.status  = out_status_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status |-> out_ch.res_num == '0 && out_ch.res_den == '0)
		else $error("error result with nonzero fields");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q != S_IDLE)
		else $error("transfer did not start the sequencer");

	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_res.done && !mul_res.done)
		else $error("arithmetic unit finished while idle");

endmodule
